>>> rtl/core/afe_pkg.sv
// Shared constants, codes and types for the multimode audio effect core.
package afe_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int OUT_BITS    = SAMPLE_BITS + 1;

	localparam int AVG_DEPTH   = 512;
	localparam int AVG_AW      = $clog2(AVG_DEPTH);
	localparam int AVG_CW      = $clog2(AVG_DEPTH + 1);
	localparam int AVG_SUM_W   = SAMPLE_BITS + AVG_CW;

	localparam int DELAY_DEPTH = 2048;
	localparam int DLY_AW      = $clog2(DELAY_DEPTH);
	localparam int DLY_CW      = $clog2(DELAY_DEPTH + 1);

	localparam int MODE_W      = 3;
	localparam int WIN_W       = 10;
	localparam int TREM_W      = 14;
	localparam int POS_W       = TREM_W + 1;
	localparam int DLEN_W      = 12;
	localparam int LVL_W       = 10;

	localparam int DIV_NW = (AVG_SUM_W > TREM_W + SAMPLE_BITS) ? AVG_SUM_W
		: TREM_W + SAMPLE_BITS;
	localparam int DIV_DW = (AVG_CW > TREM_W) ? AVG_CW : TREM_W;
	localparam int DIV_CNT_W = $clog2(DIV_NW);

	localparam int APB_AW = 5;

	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_AVG_WIN   = 3'd1;
	localparam logic [2:0] REG_TREM_HALF = 3'd2;
	localparam logic [2:0] REG_DLY_LEN   = 3'd3;
	localparam logic [2:0] REG_DB_LOW    = 3'd4;
	localparam logic [2:0] REG_DB_HIGH   = 3'd5;
	localparam logic [2:0] REG_MIDPOINT  = 3'd6;

	localparam logic [MODE_W-1:0] MODE_PASS    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOWPASS = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HIPASS  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MAVG    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TREMOLO = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ECHO    = 3'd5;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/core/afe_stream_if.sv
// Sample and result stream interfaces with valid/ready handshake.
interface afe_in_if import afe_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface afe_out_if import afe_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] out_sample;
	modport source (output valid, output out_sample, input ready);
	modport sink (input valid, input out_sample, output ready);
endinterface

>>> rtl/core/afe_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module afe_divider import afe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_DW:0]      rem_q;
	logic [DIV_NW-1:0]    quo_q;
	logic [DIV_DW-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DW:0]      rem_sh;
	logic                 fits;

	assign rem_sh = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/core/audio_effects_multimode_core.sv
// Multimode audio effect core: sequencer, rings, registers and shared divider.
//  channel   | dir | signals                          | accepted when
//  samples   | in  | valid ready sample[9:0]          | valid && ready
//  results   | out | valid ready out_sample[10:0] s   | valid && ready
//  apb       | in  | psel penable pwrite paddr pwdata | psel&&penable&&pwrite
// Pass, lowpass, highpass, tremolo dead band and echo go through the idle, read, calc and done states.
// Moving average and tremolo gain add a divide state after calc: the shared divider
// resolves one quotient bit per cycle. The read step covers the registered ring RAM reads.
// Reset sets registers and pointers at once; ring contents are never read unwritten.
// A stalled result holds; the next sample is taken while it waits.
module audio_effects_multimode_core import afe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	afe_in_if.sink            samples,
	afe_out_if.source         results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_CALC = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;

	logic [MODE_W-1:0] mode_q;
	logic [WIN_W-1:0]  avg_window_q;
	logic [TREM_W-1:0] trem_half_q;
	logic [DLEN_W-1:0] delay_len_q;
	logic [LVL_W-1:0]  db_low_q, db_high_q, midpoint_q;

	logic [SAMPLE_BITS-1:0] sample_q, last_level_q;
	logic [AVG_AW-1:0]      avg_head_q;
	logic [AVG_CW-1:0]      avg_count_q;
	logic [AVG_SUM_W-1:0]   avg_sum_q;
	logic [POS_W-1:0]       trem_pos_q;
	logic [DLY_AW-1:0]      delay_head_q;
	logic [DLY_CW-1:0]      delay_count_q;
	logic                   neg_q;
	logic signed [OUT_BITS-1:0] res_q, out_q;
	logic                   out_valid_q;

	logic [SAMPLE_BITS-1:0] avg_ring [AVG_DEPTH];
	logic [SAMPLE_BITS-1:0] delay_ring [DELAY_DEPTH];
	logic [SAMPLE_BITS-1:0] avg_rd_q, delay_rd_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	afe_divider u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	logic       cfg_wr;
	logic [2:0] cfg_idx;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_comb begin
		case (cfg_idx)
			REG_MODE:      prdata = 32'(mode_q);
			REG_AVG_WIN:   prdata = 32'(avg_window_q);
			REG_TREM_HALF: prdata = 32'(trem_half_q);
			REG_DLY_LEN:   prdata = 32'(delay_len_q);
			REG_DB_LOW:    prdata = 32'(db_low_q);
			REG_DB_HIGH:   prdata = 32'(db_high_q);
			REG_MIDPOINT:  prdata = 32'(midpoint_q);
			default:       prdata = '0;
		endcase
	end

	// ring capacities and oldest-entry addresses
	logic [AVG_CW-1:0] avg_cap;
	logic [DLY_CW-1:0] dly_cap;
	logic [AVG_AW-1:0] avg_old, avg_next;
	logic [DLY_AW-1:0] dly_old, dly_next;
	logic              avg_full, dly_full;

	always_comb begin
		if (avg_window_q == '0) avg_cap = AVG_CW'(1);
		else if (32'(avg_window_q) > AVG_DEPTH) avg_cap = AVG_CW'(AVG_DEPTH);
		else avg_cap = AVG_CW'(avg_window_q);
		if (delay_len_q == '0) dly_cap = DLY_CW'(1);
		else if (32'(delay_len_q) > DELAY_DEPTH) dly_cap = DLY_CW'(DELAY_DEPTH);
		else dly_cap = DLY_CW'(delay_len_q);
		avg_old = AVG_AW'((32'(avg_head_q) >= 32'(avg_count_q))
			? 32'(avg_head_q) - 32'(avg_count_q)
			: 32'(avg_head_q) + AVG_DEPTH - 32'(avg_count_q));
		dly_old = DLY_AW'((32'(delay_head_q) >= 32'(delay_count_q))
			? 32'(delay_head_q) - 32'(delay_count_q)
			: 32'(delay_head_q) + DELAY_DEPTH - 32'(delay_count_q));
		avg_next = (32'(avg_head_q) == AVG_DEPTH - 1) ? '0 : avg_head_q + 1'b1;
		dly_next = (32'(delay_head_q) == DELAY_DEPTH - 1) ? '0 : delay_head_q + 1'b1;
		avg_full = avg_count_q >= avg_cap;
		dly_full = delay_count_q >= dly_cap;
	end

	always_ff @(posedge clk) begin
		avg_rd_q   <= avg_ring[avg_old];
		delay_rd_q <= delay_ring[dly_old];
	end

	// datapath of the calculation step
	logic [SAMPLE_BITS:0]     lvl_sum;
	logic [SAMPLE_BITS-1:0]   avg2;
	logic [SAMPLE_BITS-1:0]   echo_e, echo_v;
	logic [SAMPLE_BITS:0]     echo_sum;
	logic [AVG_SUM_W-1:0]     mavg_sum;
	logic [AVG_CW-1:0]        mavg_cnt;
	logic [TREM_W-1:0]        len;
	logic [POS_W-1:0]         len2, pos_w, gain;
	logic                     in_band;
	logic signed [SAMPLE_BITS+1:0] diff;
	logic [SAMPLE_BITS:0]     diff_mag;
	logic [TREM_W+SAMPLE_BITS-1:0] prod;
	logic signed [SAMPLE_BITS+1:0] qs, trem_res;

	always_comb begin
		lvl_sum  = {1'b0, last_level_q} + {1'b0, sample_q};
		avg2     = lvl_sum[SAMPLE_BITS:1];
		echo_e   = dly_full ? delay_rd_q : '0;
		echo_sum = {1'b0, avg2} + {1'b0, echo_e};
		echo_v   = echo_sum[SAMPLE_BITS:1];
		mavg_sum = avg_sum_q - (avg_full ? AVG_SUM_W'(avg_rd_q) : '0)
			+ AVG_SUM_W'(sample_q);
		mavg_cnt = avg_full ? avg_count_q : avg_count_q + 1'b1;
		len      = (trem_half_q == '0) ? TREM_W'(1) : trem_half_q;
		len2     = {len, 1'b0};
		pos_w    = (trem_pos_q >= len2) ? '0 : trem_pos_q;
		gain     = (pos_w < {1'b0, len}) ? pos_w : len2 - pos_w;
		in_band  = (avg2 > db_low_q) && (avg2 < db_high_q);
		diff     = $signed({2'b00, avg2}) - $signed({2'b00, midpoint_q});
		diff_mag = diff[SAMPLE_BITS+1] ? (SAMPLE_BITS+1)'(-diff) : diff[SAMPLE_BITS:0];
		prod     = gain[TREM_W-1:0] * diff_mag[SAMPLE_BITS-1:0];
		qs       = $signed({2'b00, div_rsp.quotient[SAMPLE_BITS-1:0]});
		trem_res = (neg_q ? -qs : qs) + $signed({2'b00, midpoint_q});
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = DIV_NW'(mavg_sum);
		div_req.divisor  = DIV_DW'(mavg_cnt);
		if (state_q == S_CALC) begin
			case (mode_q)
				MODE_MAVG: div_req.start = 1'b1;
				MODE_TREMOLO: begin
					div_req.start    = !in_band;
					div_req.dividend = DIV_NW'(prod);
					div_req.divisor  = DIV_DW'(len);
				end
				default: div_req.start = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CALC) begin
			if (mode_q == MODE_MAVG) avg_ring[avg_head_q] <= sample_q;
			if (mode_q == MODE_ECHO) delay_ring[delay_head_q] <= echo_v;
		end
	end

	assign samples.ready = state_q == S_IDLE;
	assign results.valid = out_valid_q;
	assign results.out_sample = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mode_q        <= MODE_LOWPASS;
			avg_window_q  <= WIN_W'(300);
			trem_half_q   <= TREM_W'(10000);
			delay_len_q   <= DLEN_W'(1500);
			db_low_q      <= LVL_W'(505);
			db_high_q     <= LVL_W'(520);
			midpoint_q    <= LVL_W'(512);
			last_level_q  <= '0;
			avg_head_q    <= '0;
			avg_count_q   <= '0;
			avg_sum_q     <= '0;
			trem_pos_q    <= '0;
			delay_head_q  <= '0;
			delay_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_MODE:      mode_q <= pwdata[MODE_W-1:0];
					REG_AVG_WIN: begin
						avg_window_q <= pwdata[WIN_W-1:0];
						avg_head_q   <= '0;
						avg_count_q  <= '0;
						avg_sum_q    <= '0;
					end
					REG_TREM_HALF: trem_half_q <= pwdata[TREM_W-1:0];
					REG_DLY_LEN: begin
						delay_len_q   <= pwdata[DLEN_W-1:0];
						delay_head_q  <= '0;
						delay_count_q <= '0;
					end
					REG_DB_LOW:    db_low_q <= pwdata[LVL_W-1:0];
					REG_DB_HIGH:   db_high_q <= pwdata[LVL_W-1:0];
					REG_MIDPOINT:  midpoint_q <= pwdata[LVL_W-1:0];
					default:       mode_q <= mode_q;
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || results.ready)) out_valid_q <= 1'b1;
			else if (results.valid && results.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (samples.valid) state_q <= S_READ;
				S_READ: state_q <= S_CALC;
				S_CALC: begin
					state_q <= (mode_q == MODE_MAVG || (mode_q == MODE_TREMOLO && !in_band))
						? S_DIV : S_DONE;
					case (mode_q)
						MODE_LOWPASS: last_level_q <= sample_q;
						MODE_HIPASS:  last_level_q <= sample_q;
						MODE_MAVG: begin
							avg_head_q  <= avg_next;
							avg_count_q <= mavg_cnt;
							avg_sum_q   <= mavg_sum;
						end
						MODE_TREMOLO: begin
							last_level_q <= sample_q;
							if (in_band) begin
								trem_pos_q <= pos_w;
							end else begin
								trem_pos_q <= pos_w + 1'b1;
							end
						end
						MODE_ECHO: begin
							delay_head_q  <= dly_next;
							delay_count_q <= dly_full ? delay_count_q
								: delay_count_q + 1'b1;
							last_level_q  <= echo_v;
						end
						default: ;
					endcase
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_DONE;
						if (mode_q == MODE_TREMOLO)
							last_level_q <= trem_res[SAMPLE_BITS-1:0];
					end
				end
				S_DONE: begin
					if (!out_valid_q || results.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && samples.valid) sample_q <= samples.sample;
		if (state_q == S_CALC) begin
			neg_q <= diff[SAMPLE_BITS+1];
			case (mode_q)
				MODE_LOWPASS: res_q <= $signed({1'b0, avg2});
				MODE_HIPASS:  res_q <= $signed({1'b0, sample_q}) - $signed({1'b0, avg2});
				MODE_TREMOLO: res_q <= $signed({1'b0, midpoint_q});
				MODE_ECHO:    res_q <= $signed({1'b0, echo_v});
				default:      res_q <= $signed({1'b0, sample_q});
			endcase
		end
		if (state_q == S_DIV && div_rsp.done) begin
			if (mode_q == MODE_TREMOLO) res_q <= trem_res[OUT_BITS-1:0];
			else res_q <= $signed({1'b0, div_rsp.quotient[SAMPLE_BITS-1:0]});
		end
		if (state_q == S_DONE && (!out_valid_q || results.ready)) out_q <= res_q;
	end

endmodule

>>> rtl/core/afe_checker.sv
// Port-level checks for the multimode audio effect core, bound to the top level.
module afe_checker import afe_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [OUT_BITS-1:0] out_sample,
	input logic                pready
);

	// a request keeps the core busy for the read and calculation steps
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("core ready too soon after a request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample))
		else $error("stalled result changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind audio_effects_multimode_core afe_checker u_afe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(samples.valid),
	.in_ready(samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_sample(results.out_sample),
	.pready(pready)
);

>>> tb/sv/afe_scoreboard.sv
// Scoreboard for the audio effect core: predicts each processed sample and checks results.
`timescale 1ns / 100ps
class afe_scoreboard;
	logic [2:0]  fx_mode;
	logic [9:0]  win_reg;
	logic [13:0] half_reg;
	logic [11:0] dlen_reg;
	logic [9:0]  db_lo, db_hi, mid_lvl;

	int unsigned level;
	int unsigned avg_buf[512];
	int unsigned avg_wr, avg_n, avg_total;
	int unsigned trem_pos;
	int unsigned echo_buf[2048];
	int unsigned echo_wr, echo_n;

	logic signed [10:0] pending_samples[$];
	int errors;
	int checked;

	function new();
		fx_mode = afe_pkg::MODE_LOWPASS;
		win_reg = 300;
		half_reg = 10000;
		dlen_reg = 1500;
		db_lo = 505;
		db_hi = 520;
		mid_lvl = 512;
		level = 0;
		trem_pos = 0;
		avg_wr = 0; avg_n = 0; avg_total = 0;
		echo_wr = 0; echo_n = 0;
		errors = 0;
		checked = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			afe_pkg::REG_MODE: fx_mode = val[2:0];
			afe_pkg::REG_AVG_WIN: begin
				win_reg = val[9:0];
				avg_wr = 0; avg_n = 0; avg_total = 0;
			end
			afe_pkg::REG_TREM_HALF: half_reg = val[13:0];
			afe_pkg::REG_DLY_LEN: begin
				dlen_reg = val[11:0];
				echo_wr = 0; echo_n = 0;
			end
			afe_pkg::REG_DB_LOW: db_lo = val[9:0];
			afe_pkg::REG_DB_HIGH: db_hi = val[9:0];
			afe_pkg::REG_MIDPOINT: mid_lvl = val[9:0];
			default: ;
		endcase
	endfunction

	function void note_sample(logic [9:0] smp);
		int unsigned s, a, cap, len, p, e, v, old;
		int gain, diff, res;
		s = smp;
		a = (level + s) >> 1;
		res = s;
		case (fx_mode)
			afe_pkg::MODE_LOWPASS: begin
				level = s;
				res = a;
			end
			afe_pkg::MODE_HIPASS: begin
				level = s;
				res = int'(s) - int'(a);
			end
			afe_pkg::MODE_MAVG: begin
				cap = (win_reg == 0) ? 1 : (win_reg > 512 ? 512 : win_reg);
				if (avg_n >= cap) begin
					old = (avg_wr + 512 - avg_n) % 512;
					avg_total -= avg_buf[old];
					avg_n--;
				end
				avg_buf[avg_wr] = s;
				avg_wr = (avg_wr + 1) % 512;
				avg_n++;
				avg_total += s;
				res = avg_total / avg_n;
			end
			afe_pkg::MODE_TREMOLO: begin
				len = (half_reg == 0) ? 1 : half_reg;
				level = s;
				if (trem_pos >= 2 * len) trem_pos = 0;
				if (a > db_lo && a < db_hi) res = mid_lvl;
				else begin
					p = trem_pos;
					gain = (p < len) ? p : 2 * len - p;
					diff = int'(a) - int'(mid_lvl);
					trem_pos = p + 1;
					res = (gain * diff) / int'(len) + int'(mid_lvl);
					level = res & 10'h3FF;
				end
			end
			afe_pkg::MODE_ECHO: begin
				cap = (dlen_reg == 0) ? 1 : (dlen_reg > 2048 ? 2048 : dlen_reg);
				e = 0;
				if (echo_n >= cap) begin
					old = (echo_wr + 2048 - echo_n) % 2048;
					e = echo_buf[old];
					echo_n--;
				end
				v = (a + e) >> 1;
				echo_buf[echo_wr] = v;
				echo_wr = (echo_wr + 1) % 2048;
				echo_n++;
				level = v;
				res = v;
			end
			default: res = s;
		endcase
		pending_samples.push_back(res[10:0]);
	endfunction

	function void check_result(logic signed [10:0] got);
		logic signed [10:0] want;
		checked++;
		if (pending_samples.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual %0d", $time, got);
			errors++;
			return;
		end
		want = pending_samples.pop_front();
		if (got !== want) begin
			$display("%0t: out_sample mismatch: expected %0d, actual %0d", $time, want, got);
			errors++;
		end
	endfunction
endclass

>>> tb/sv/testbench.sv
// Top-level testbench for the multimode audio effect core.
`timescale 1ns / 100ps
module testbench;
	import afe_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	afe_in_if samples();
	afe_out_if results();

	audio_effects_multimode_core DUT (
		.clk(clk), .arst_n(arst_n), .samples(samples), .results(results),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	afe_scoreboard fx_board = new();
	int send_idle_pct = 36;
	int recv_idle_pct = 64;
	int idle_cycles = 0;
	int sent_count = 0;
	bit timed_out = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		samples.valid = 1'b0;
		samples.sample = '0;
		results.ready = 1'b0;
	end

	// receiver: sample at rising edge, change ready at falling edge
	always @(posedge clk) begin
		if (results.valid && results.ready) fx_board.check_result(results.out_sample);
		if ((samples.valid && samples.ready) || (results.valid && results.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("[audio_effects_multimode_core] ERROR");
			$finish;
		end
	end

	always @(negedge clk)
		results.ready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= APB_AW'(idx) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		fx_board.write_reg(idx, val);
	endtask

	task automatic send_sample(logic [9:0] smp);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		samples.valid <= 1'b1;
		samples.sample <= smp;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		fx_board.note_sample(smp);
		sent_count++;
		@(negedge clk);
		samples.valid <= 1'b0;
	endtask

	// wait for every pending result, then let the core settle
	task automatic drain();
		while (fx_board.pending_samples.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [9:0] rand_sample();
		case ($urandom_range(5))
			0: return 10'd0;
			1: return 10'd1023;
			2: return 10'($urandom_range(540, 485));
			default: return 10'($urandom);
		endcase
	endfunction

	task automatic random_config();
		reg_write(REG_AVG_WIN, $urandom_range(3) == 0 ? 32'($urandom_range(1023))
			: 32'($urandom_range(8)));
		reg_write(REG_TREM_HALF, $urandom_range(5) == 0 ? 32'($urandom_range(16383))
			: 32'($urandom_range(20)));
		reg_write(REG_DLY_LEN, $urandom_range(5) == 0 ? 32'($urandom_range(4095))
			: 32'($urandom_range(16)));
		reg_write(REG_DB_LOW, $urandom_range(1023));
		reg_write(REG_DB_HIGH, $urandom_range(1023));
		reg_write(REG_MIDPOINT, $urandom_range(1) ? 32'd512 : 32'($urandom_range(1023)));
		reg_write(REG_MODE, $urandom_range(7));
	endtask

	initial begin
		logic [2:0] m;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset settings, extremes, every mode, unknown modes
		send_sample(10'd1023);
		send_sample(10'd0);
		drain();
		reg_write(REG_AVG_WIN, 0);
		reg_write(REG_DLY_LEN, 0);
		reg_write(REG_TREM_HALF, 0);
		for (m = 0; m < 7; m++) begin
			drain();
			reg_write(REG_MODE, m);
			send_sample(10'd1023);
			send_sample(10'd0);
			send_sample(10'd512);
		end
		drain();
		reg_write(REG_MODE, 3'd7);
		send_sample(10'h2AA);
		send_sample(10'h155);
		drain();
		reg_write(REG_AVG_WIN, 1023);
		reg_write(REG_DLY_LEN, 4095);
		reg_write(REG_TREM_HALF, 16383);
		reg_write(REG_DB_LOW, 1023);
		reg_write(REG_DB_HIGH, 0);
		reg_write(REG_MIDPOINT, 0);
		reg_write(REG_MODE, MODE_TREMOLO);
		send_sample(10'd1023);
		send_sample(10'd1023);
		drain();
		reg_write(REG_MIDPOINT, 1023);
		reg_write(REG_MODE, MODE_HIPASS);
		send_sample(10'd1023);

		// random phases with three idling profiles
		for (int ph = 0; ph < 39; ph++) begin
			if (ph == 13) begin send_idle_pct = 64; recv_idle_pct = 36; end
			if (ph == 26) begin send_idle_pct = 0; recv_idle_pct = 0; end
			drain();
			random_config();
			repeat (33) send_sample(rand_sample());
		end

		drain();
		$display("Sent %0d samples through all modes and register extremes; %0d results checked.",
			sent_count, fx_board.checked);
		if (fx_board.errors == 0 && fx_board.pending_samples.size() == 0)
			$display("[audio_effects_multimode_core] OK");
		else
			$display("[audio_effects_multimode_core] ERROR");
		$finish;
	end
endmodule
